### src/page_refcount_table_top_macros.svh
// Assertion macros shared by the checker of the page reference count table.
// Depends on nothing; included by the checker file.
`ifndef PAGE_REFCOUNT_TABLE_TOP_MACROS_SVH
`define PAGE_REFCOUNT_TABLE_TOP_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define PRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define PRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check that a condition implies another at a later cycle.
`define PRT_ASSERT_TWO(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

### src/prt_pkg.sv
// Package of the page reference count table: sizes, operation codes,
// register indexes and the controller command struct. Depends on nothing.
package prt_pkg;

  // Sizes of the table
  localparam int unsigned PAGE_BYTES  = 4096;
  localparam int unsigned NUM_PAGES   = 4096;
  localparam int unsigned COUNT_BITS  = 16;

  // Fixed field widths
  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned FUNC_W      = 4;
  localparam int unsigned CFG_W       = 13;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned OUT_COUNT_W = 16;

  // Derived widths
  localparam int unsigned PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int unsigned PAGE_IDX_W  = ADDR_W - PAGE_SHIFT;
  localparam int unsigned IDX_W       = $clog2(NUM_PAGES);

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_TRY_REF      = 4'd0,
    FN_UNREF        = 4'd1,
    FN_RELEASE      = 4'd2,
    FN_CAN_FREE     = 4'd3,
    FN_IS_MANAGED   = 4'd4,
    FN_READ         = 4'd5,
    FN_FORCE_REF    = 4'd6,
    FN_RELEASE_LAST = 4'd7,
    FN_SET_MANAGED  = 4'd8
  } func_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_LIMIT  = 2'd0,
    CFG_MAP_LENGTH  = 2'd1,
    CFG_TABLE_READY = 2'd2
  } cfg_idx_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             load;      // capture a request and read both memories
    logic             exec;      // evaluate, write back, register the result
    logic             clr_we;    // clearing pass writes one entry
    logic [IDX_W-1:0] clr_addr;  // entry cleared this cycle
  } cmd_t;

endpackage

### src/page_refcount_table_top.sv
// Top level of the page reference count table: controller and datapath.
// Depends on prt_pkg, prt_ctrl and prt_datapath.
//
// Keeps a saturating reference count per page and a managed-page bitmap.
// After reset the block runs a clearing pass over every entry of both
// memories with busy high; configuration writes are taken throughout.
// A request is accepted when start is high and busy is low. Each request
// reads the count and bitmap entries from their RAMs (registered read),
// then evaluates and writes back. The result appears on the out_ ports
// the cycle after that, strobed by out_valid for one cycle, and cannot
// be stalled; the next request may be accepted in that same cycle. The
// user must write configuration only while no request is in flight; the
// block does not enforce it.
module page_refcount_table_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [prt_pkg::FUNC_W-1:0]      in_func,
  input  logic [prt_pkg::ADDR_W-1:0]      in_address,
  input  logic                            in_managed_value,
  output logic                            out_valid,
  output logic                            out_ok,
  output logic [prt_pkg::OUT_COUNT_W-1:0] out_count,
  output logic                            out_freed,
  output logic                            out_managed,
  output logic                            out_overflow,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [prt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [prt_pkg::CFG_W-1:0]       cfg_data
);

  prt_pkg::cmd_t cmd;

  // Take configuration writes at any time
  assign cfg_ready = 1'b1;

  prt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  prt_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_func          (in_func),
    .in_address       (in_address),
    .in_managed_value (in_managed_value),
    .out_ok           (out_ok),
    .out_count        (out_count),
    .out_freed        (out_freed),
    .out_managed      (out_managed),
    .out_overflow     (out_overflow)
  );

endmodule

### src/prt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module prt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/prt_ctrl.sv
// Controller of the page reference count table: clearing pass after reset,
// request acceptance and result strobe. Depends on prt_pkg.
module prt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_valid,
  output prt_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                    state_r, state_nxt;
  logic [prt_pkg::IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Next state
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + prt_pkg::IDX_W'(1);
        if (clr_cnt_r == prt_pkg::IDX_W'(prt_pkg::NUM_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Hold state, clear counter and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Drive datapath commands
  always_comb begin
    cmd.load     = accept;
    cmd.exec     = (state_r == S_EXEC);
    cmd.clr_we   = (state_r == S_CLEAR);
    cmd.clr_addr = clr_cnt_r;
  end

  assign out_valid = out_valid_r;

endmodule

### src/prt_datapath.sv
// Datapath of the page reference count table: configuration registers,
// count and bitmap memories, operation evaluation and result registers.
// Depends on prt_pkg and prt_ram.
module prt_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  prt_pkg::cmd_t                   cmd,
  input  logic                            cfg_we,
  input  logic [prt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [prt_pkg::CFG_W-1:0]       cfg_data,
  input  logic [prt_pkg::FUNC_W-1:0]      in_func,
  input  logic [prt_pkg::ADDR_W-1:0]      in_address,
  input  logic                            in_managed_value,
  output logic                            out_ok,
  output logic [prt_pkg::OUT_COUNT_W-1:0] out_count,
  output logic                            out_freed,
  output logic                            out_managed,
  output logic                            out_overflow
);

  localparam logic [prt_pkg::COUNT_BITS-1:0] CntMax = '1;

  // Configuration
  logic [prt_pkg::CFG_W-1:0] page_limit_r;
  logic [prt_pkg::CFG_W-1:0] map_length_r;
  logic                      table_ready_r;

  // Captured request
  logic [prt_pkg::FUNC_W-1:0]     func_r;
  logic [prt_pkg::PAGE_IDX_W-1:0] pidx_r;
  logic                           mval_r;

  // Memory ports
  logic                           cnt_we, map_we;
  logic [prt_pkg::IDX_W-1:0]      waddr;
  logic [prt_pkg::COUNT_BITS-1:0] cnt_wdata, cnt_rdata, cnt_new;
  logic                           map_wdata, map_rdata;
  logic [prt_pkg::PAGE_IDX_W-1:0] in_pidx;

  // Evaluation
  logic                           in_store, in_table, managed;
  logic                           nz, at_max, is_one;
  logic [prt_pkg::COUNT_BITS-1:0] cnt_inc, cnt_dec;
  logic                           ok_c, freed_c, ovf_c, upd_c, map_upd_c;
  logic [prt_pkg::COUNT_BITS-1:0] cnt_c;

  // Result registers
  logic                           ok_r, freed_r, managed_r, ovf_r;
  logic [prt_pkg::COUNT_BITS-1:0] cnt_r;

  // Write configuration registers; ignore indexes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_limit_r  <= '0;
      map_length_r  <= '0;
      table_ready_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (prt_pkg::cfg_idx_t'(cfg_index))
        prt_pkg::CFG_PAGE_LIMIT:  page_limit_r  <= cfg_data;
        prt_pkg::CFG_MAP_LENGTH:  map_length_r  <= cfg_data;
        prt_pkg::CFG_TABLE_READY: table_ready_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture the request
  assign in_pidx = in_address[prt_pkg::ADDR_W-1:prt_pkg::PAGE_SHIFT];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      pidx_r <= in_pidx;
      mval_r <= in_managed_value;
    end
  end

  // Memory writes: clearing pass or write-back of the current request
  assign waddr     = cmd.clr_we ? cmd.clr_addr : pidx_r[prt_pkg::IDX_W-1:0];
  assign cnt_we    = cmd.clr_we || (cmd.exec && upd_c);
  assign map_we    = cmd.clr_we || (cmd.exec && map_upd_c);
  assign cnt_wdata = cmd.clr_we ? '0 : cnt_new;
  assign map_wdata = cmd.clr_we ? 1'b0 : mval_r;

  prt_ram #(
    .WIDTH (prt_pkg::COUNT_BITS),
    .DEPTH (prt_pkg::NUM_PAGES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (waddr),
    .wdata (cnt_wdata),
    .re    (cmd.load),
    .raddr (in_pidx[prt_pkg::IDX_W-1:0]),
    .rdata (cnt_rdata)
  );

  prt_ram #(
    .WIDTH (1),
    .DEPTH (prt_pkg::NUM_PAGES)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (waddr),
    .wdata (map_wdata),
    .re    (cmd.load),
    .raddr (in_pidx[prt_pkg::IDX_W-1:0]),
    .rdata (map_rdata)
  );

  // Classify the page
  assign in_store = pidx_r < prt_pkg::PAGE_IDX_W'(prt_pkg::NUM_PAGES);
  assign in_table = table_ready_r && in_store
                    && (pidx_r < prt_pkg::PAGE_IDX_W'(page_limit_r));
  assign managed  = in_table && (pidx_r < prt_pkg::PAGE_IDX_W'(map_length_r))
                    && map_rdata;

  assign nz      = (cnt_rdata != '0);
  assign at_max  = (cnt_rdata == CntMax);
  assign is_one  = (cnt_rdata == prt_pkg::COUNT_BITS'(1));
  assign cnt_inc = at_max ? cnt_rdata : cnt_rdata + prt_pkg::COUNT_BITS'(1);
  assign cnt_dec = cnt_rdata - prt_pkg::COUNT_BITS'(1);

  // Evaluate the operation
  always_comb begin
    ok_c      = 1'b0;
    freed_c   = 1'b0;
    ovf_c     = 1'b0;
    upd_c     = 1'b0;
    map_upd_c = 1'b0;
    cnt_c     = '0;
    cnt_new   = cnt_rdata;
    unique case (prt_pkg::func_t'(func_r))
      prt_pkg::FN_TRY_REF: begin
        if (!managed) begin
          ok_c = 1'b1;
        end else if (nz) begin
          ovf_c   = at_max;
          cnt_new = cnt_inc;
          upd_c   = 1'b1;
          ok_c    = 1'b1;
          cnt_c   = cnt_inc;
        end
      end
      prt_pkg::FN_UNREF, prt_pkg::FN_RELEASE: begin
        if (managed && nz) begin
          cnt_new = cnt_dec;
          upd_c   = 1'b1;
          ok_c    = 1'b1;
          cnt_c   = cnt_dec;
          freed_c = (prt_pkg::func_t'(func_r) == prt_pkg::FN_RELEASE) && is_one;
        end
      end
      prt_pkg::FN_CAN_FREE: begin
        if (managed) begin
          cnt_c = cnt_rdata;
          ok_c  = !nz;
        end
      end
      prt_pkg::FN_IS_MANAGED: begin
        ok_c = managed;
        if (managed) begin
          cnt_c = cnt_rdata;
        end
      end
      prt_pkg::FN_READ: begin
        if (in_table) begin
          ok_c  = 1'b1;
          cnt_c = cnt_rdata;
        end
      end
      prt_pkg::FN_FORCE_REF: begin
        if (in_table) begin
          ovf_c   = at_max;
          cnt_new = cnt_inc;
          upd_c   = 1'b1;
          ok_c    = 1'b1;
          cnt_c   = cnt_inc;
        end
      end
      prt_pkg::FN_RELEASE_LAST: begin
        if (in_table) begin
          if (is_one) begin
            cnt_new = '0;
            upd_c   = 1'b1;
            ok_c    = 1'b1;
          end else begin
            cnt_c = cnt_rdata;
          end
        end
      end
      prt_pkg::FN_SET_MANAGED: begin
        if (in_store) begin
          map_upd_c = 1'b1;
          ok_c      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_r      <= ok_c;
      cnt_r     <= cnt_c;
      freed_r   <= freed_c;
      managed_r <= managed;
      ovf_r     <= ovf_c;
    end
  end

  assign out_ok       = ok_r;
  assign out_count    = prt_pkg::OUT_COUNT_W'(cnt_r);
  assign out_freed    = freed_r;
  assign out_managed  = managed_r;
  assign out_overflow = ovf_r;

endmodule

### src/prt_checker.sv
// Port-level checker of the page reference count table, bound to the top.
// Depends on prt_pkg and page_refcount_table_top_macros.svh.
`include "page_refcount_table_top_macros.svh"

module prt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_valid,
  input logic                            out_ok,
  input logic [prt_pkg::OUT_COUNT_W-1:0] out_count,
  input logic                            out_freed,
  input logic                            out_overflow
);

  logic accept;

  assign accept = start && !busy;

  // Every accepted request gives its result once it has been evaluated
  `PRT_ASSERT_TWO(a_result_follows, clk, rst_n, accept, out_valid, "result missing")
  // Hold off new requests while one is in flight
  `PRT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, busy, "busy not raised")
  // Results never come in consecutive cycles
  `PRT_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid, "double strobe")
  // A freed page succeeded and ended at zero
  `PRT_ASSERT_NOW(a_freed_zero, clk, rst_n, out_valid && out_freed,
                  out_ok && (out_count == '0), "freed with nonzero count")
  // A saturated increment succeeded and holds the counter at its maximum
  `PRT_ASSERT_NOW(a_overflow_max, clk, rst_n, out_valid && out_overflow,
                  out_ok && (out_count == '1), "overflow below maximum")

endmodule

bind page_refcount_table_top prt_checker u_prt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_ok       (out_ok),
  .out_count    (out_count),
  .out_freed    (out_freed),
  .out_overflow (out_overflow)
);

### tb/sv/page_refcount_table_top_tb.sv
// Self-checking testbench of the page reference count table top level.
// Depends on prt_pkg and page_refcount_table_top; predicts every result itself.
`timescale 1ns / 1ps

module page_refcount_table_top_tb;
  import prt_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX         = '1;
  localparam logic [FUNC_W-1:0]     FN_FIRST_UNUSED = FN_SET_MANAGED + 1;
  localparam logic [FUNC_W-1:0]     FN_TOP_CODE     = '1;
  localparam int unsigned           CFG_TOP         = (1 << CFG_W) - 1;
  localparam int unsigned           DEEP_PAGE       = NUM_PAGES - 1;

  typedef struct packed {
    logic                   ok;
    logic [OUT_COUNT_W-1:0] count;
    logic                   freed;
    logic                   managed;
    logic                   overflow;
  } outcome_t;

  typedef struct {
    logic [FUNC_W-1:0] fn;
    logic [ADDR_W-1:0] addr;
    outcome_t          res;
  } request_rec_t;

  logic                   clk              = 1'b0;
  logic                   rst_n            = 1'b0;
  logic                   start            = 1'b0;
  logic                   busy;
  logic [FUNC_W-1:0]      in_func          = '0;
  logic [ADDR_W-1:0]      in_address       = '0;
  logic                   in_managed_value = 1'b0;
  logic                   out_valid;
  logic                   out_ok;
  logic [OUT_COUNT_W-1:0] out_count;
  logic                   out_freed;
  logic                   out_managed;
  logic                   out_overflow;
  logic                   cfg_valid        = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index        = CFG_PAGE_LIMIT;
  logic [CFG_W-1:0]       cfg_data         = '0;

  // Shadow copy of the table and its registers
  logic [COUNT_BITS-1:0] page_counts  [NUM_PAGES];
  logic                  managed_bits [NUM_PAGES];
  logic [CFG_W-1:0]      limit_pages;
  logic [CFG_W-1:0]      map_len;
  logic                  tbl_ready;

  request_rec_t pending_outcomes [$];
  int unsigned  fault_count = 0;
  int unsigned  idle_pct    = 0;

  always #1 clk = ~clk;

  page_refcount_table_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_address       (in_address),
    .in_managed_value (in_managed_value),
    .out_valid        (out_valid),
    .out_ok           (out_ok),
    .out_count        (out_count),
    .out_freed        (out_freed),
    .out_managed      (out_managed),
    .out_overflow     (out_overflow),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Compute the result of one request and update the shadow table
  function automatic outcome_t refcount_outcome(input logic [FUNC_W-1:0] fn,
                                                input logic [ADDR_W-1:0] addr,
                                                input logic              mval);
    logic [PAGE_IDX_W-1:0] pidx;
    logic [IDX_W-1:0]      slot;
    logic                  in_store;
    logic                  in_table;
    logic                  on_map;
    logic [COUNT_BITS-1:0] cur;
    outcome_t              r;
    pidx     = addr[ADDR_W-1:PAGE_SHIFT];
    slot     = pidx[IDX_W-1:0];
    in_store = pidx < NUM_PAGES;
    in_table = tbl_ready && in_store && (pidx < limit_pages);
    on_map   = in_table && (pidx < map_len) && managed_bits[slot];
    cur      = page_counts[slot];
    r        = '0;
    r.managed = on_map;
    case (fn)
      FN_TRY_REF: begin
        // unmanaged pages always succeed; a zero count refuses the reference
        if (!on_map) begin
          r.ok = 1'b1;
        end else if (cur != 0) begin
          if (cur == CNT_MAX) r.overflow = 1'b1;
          else cur = cur + 1'b1;
          r.ok    = 1'b1;
          r.count = cur;
        end
      end
      FN_UNREF, FN_RELEASE: begin
        if (on_map) begin
          if (cur != 0) begin
            cur     = cur - 1'b1;
            r.ok    = 1'b1;
            r.freed = (fn == FN_RELEASE) && (cur == 0);
          end
          r.count = cur;
        end
      end
      FN_CAN_FREE: begin
        if (on_map) begin
          r.count = cur;
          r.ok    = (cur == 0);
        end
      end
      FN_IS_MANAGED: begin
        r.ok = on_map;
        if (on_map) r.count = cur;
      end
      FN_READ: begin
        if (in_table) begin
          r.ok    = 1'b1;
          r.count = cur;
        end
      end
      FN_FORCE_REF: begin
        if (in_table) begin
          if (cur == CNT_MAX) r.overflow = 1'b1;
          else cur = cur + 1'b1;
          r.ok    = 1'b1;
          r.count = cur;
        end
      end
      FN_RELEASE_LAST: begin
        if (in_table) begin
          if (cur == 1) begin
            cur  = '0;
            r.ok = 1'b1;
          end
          r.count = cur;
        end
      end
      FN_SET_MANAGED: begin
        if (in_store) begin
          managed_bits[slot] = mval;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    if (in_store) page_counts[slot] = cur;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] page_addr(input logic [PAGE_IDX_W-1:0] pidx,
                                                  input logic [PAGE_SHIFT-1:0] ofs);
    return {pidx, ofs};
  endfunction

  function automatic logic [CFG_W-1:0] pick_register_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return NUM_PAGES;
      2:       return $urandom_range(1, 64);
      3:       return $urandom_range(NUM_PAGES + 1, CFG_TOP);
      default: return $urandom_range(0, NUM_PAGES);
    endcase
  endfunction

  // Send one request, with an optional idle burst ahead of it
  task automatic issue_request(input logic [FUNC_W-1:0] fn, input logic [ADDR_W-1:0] addr,
                               input logic mval);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start            <= 1'b1;
    in_func          <= fn;
    in_address       <= addr;
    in_managed_value <= mval;
    do @(posedge clk); while (busy);
    pending_outcomes.push_back('{fn, addr, refcount_outcome(fn, addr, mval)});
  endtask

  // Drop start and wait for every outstanding result, with a limit
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    start <= 1'b0;
    while (pending_outcomes.size() != 0 && waited < 64) begin
      @(posedge clk);
      waited++;
    end
    if (pending_outcomes.size() != 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("missing results: %0d request(s) never answered", pending_outcomes.size());
      pending_outcomes.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PAGE_LIMIT:  limit_pages = value;
      CFG_MAP_LENGTH:  map_len     = value;
      CFG_TABLE_READY: tbl_ready   = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Reprogram all registers once the block has gone idle
  task automatic configure(input logic [CFG_W-1:0] lim, input logic [CFG_W-1:0] mlen,
                           input logic ready);
    drain_results();
    write_register(CFG_PAGE_LIMIT, lim);
    write_register(CFG_MAP_LENGTH, mlen);
    write_register(CFG_TABLE_READY, ready);
  endtask

  // Random request: mostly a small pool of pages so counts build up and drain
  task automatic random_request();
    int unsigned           pick;
    logic [FUNC_W-1:0]     fn;
    logic [PAGE_IDX_W-1:0] pidx;
    logic [63:0]           wide;
    logic [31:0]           ofs;
    pick = $urandom_range(0, 99);
    if (pick < 14)      fn = FN_TRY_REF;
    else if (pick < 24) fn = FN_UNREF;
    else if (pick < 36) fn = FN_RELEASE;
    else if (pick < 42) fn = FN_CAN_FREE;
    else if (pick < 47) fn = FN_IS_MANAGED;
    else if (pick < 53) fn = FN_READ;
    else if (pick < 71) fn = FN_FORCE_REF;
    else if (pick < 78) fn = FN_RELEASE_LAST;
    else if (pick < 96) fn = FN_SET_MANAGED;
    else                fn = $urandom_range(FN_FIRST_UNUSED, FN_TOP_CODE);
    pick = $urandom_range(0, 99);
    wide = {$urandom, $urandom};
    if (pick < 60)      pidx = $urandom_range(0, 15);
    else if (pick < 75) pidx = limit_pages - 2 + $urandom_range(0, 3);
    else if (pick < 88) pidx = map_len - 2 + $urandom_range(0, 3);
    else if (pick < 94) pidx = NUM_PAGES - 1 + $urandom_range(0, 1);
    else                pidx = wide[ADDR_W-1:PAGE_SHIFT];
    ofs = $urandom_range(0, PAGE_BYTES - 1);
    issue_request(fn, page_addr(pidx, ofs[PAGE_SHIFT-1:0]), $urandom_range(0, 3) != 0);
  endtask

  // Registers at reset: table not ready, so only the bitmap can change
  task automatic test_reset_state();
    issue_request(FN_TRY_REF, page_addr(0, '0), 1'b0);
    issue_request(FN_READ, page_addr(3, '1), 1'b0);
    issue_request(FN_FORCE_REF, page_addr(3, '0), 1'b0);
    issue_request(FN_SET_MANAGED, page_addr(5, 12'h123), 1'b1);
    issue_request(FN_IS_MANAGED, page_addr(5, '0), 1'b0);
    drain_results();
  endtask

  // Walk every operation through its cases on a few pages
  task automatic test_operations();
    configure(NUM_PAGES, NUM_PAGES, 1'b1);
    issue_request(FN_TRY_REF, page_addr(5, '0), 1'b0);
    issue_request(FN_FORCE_REF, page_addr(5, 12'h010), 1'b0);
    issue_request(FN_TRY_REF, page_addr(5, '1), 1'b0);
    issue_request(FN_CAN_FREE, page_addr(5, '0), 1'b0);
    issue_request(FN_IS_MANAGED, page_addr(5, '0), 1'b0);
    issue_request(FN_UNREF, page_addr(5, '0), 1'b0);
    issue_request(FN_RELEASE, page_addr(5, '0), 1'b0);
    issue_request(FN_RELEASE, page_addr(5, '0), 1'b0);
    issue_request(FN_UNREF, page_addr(5, '0), 1'b0);
    issue_request(FN_CAN_FREE, page_addr(5, '0), 1'b0);
    issue_request(FN_RELEASE_LAST, page_addr(5, '0), 1'b0);
    issue_request(FN_FORCE_REF, page_addr(5, '0), 1'b0);
    issue_request(FN_RELEASE_LAST, page_addr(5, '0), 1'b0);
    issue_request(FN_READ, page_addr(5, '0), 1'b0);
    // in the table but not in the bitmap
    issue_request(FN_READ, page_addr(6, '0), 1'b0);
    issue_request(FN_TRY_REF, page_addr(6, '0), 1'b0);
    // far outside the table
    issue_request(FN_SET_MANAGED, '1, 1'b1);
    issue_request(FN_TRY_REF, '1, 1'b0);
    issue_request(FN_SET_MANAGED, page_addr(NUM_PAGES, '0), 1'b1);
    // last page of the table
    issue_request(FN_SET_MANAGED, page_addr(NUM_PAGES - 1, '0), 1'b1);
    issue_request(FN_FORCE_REF, page_addr(NUM_PAGES - 1, '1), 1'b0);
    issue_request(FN_IS_MANAGED, page_addr(NUM_PAGES - 1, '0), 1'b0);
    // unused operation codes
    issue_request(FN_FIRST_UNUSED, page_addr(5, '0), 1'b1);
    issue_request(FN_TOP_CODE, page_addr(5, '0), 1'b1);
    issue_request(FN_SET_MANAGED, page_addr(5, '0), 1'b0);
    issue_request(FN_IS_MANAGED, page_addr(5, '0), 1'b0);
  endtask

  // Empty, tiny, oversized and disabled tables
  task automatic test_register_extremes();
    logic [CFG_W-1:0] limits [6];
    logic [CFG_W-1:0] maps   [6];
    logic             readys [6];
    limits = '{0, NUM_PAGES, 1, CFG_TOP, NUM_PAGES, NUM_PAGES - 1};
    maps   = '{NUM_PAGES, 0, 1, CFG_TOP, NUM_PAGES, 7};
    readys = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    idle_pct = 25;
    for (int k = 0; k < 6; k++) begin
      configure(limits[k], maps[k], readys[k]);
      repeat (40) random_request();
    end
  endtask

  // Build one counter up well past one, then walk it back down to zero and try to go past it
  task automatic test_deep_count();
    configure(NUM_PAGES, NUM_PAGES, 1'b1);
    idle_pct = 0;
    issue_request(FN_SET_MANAGED, page_addr(DEEP_PAGE, '0), 1'b1);
    repeat (40) issue_request(FN_FORCE_REF, page_addr(DEEP_PAGE, '0), 1'b0);
    issue_request(FN_TRY_REF, page_addr(DEEP_PAGE, '0), 1'b0);
    issue_request(FN_RELEASE_LAST, page_addr(DEEP_PAGE, '0), 1'b0);
    repeat (43) issue_request(FN_RELEASE, page_addr(DEEP_PAGE, '0), 1'b0);
    issue_request(FN_UNREF, page_addr(DEEP_PAGE, '0), 1'b0);
    issue_request(FN_TRY_REF, page_addr(DEEP_PAGE, '0), 1'b0);
  endtask

  // Random traffic over a series of register settings; last phase runs flat out
  task automatic test_random_traffic();
    for (int phase = 0; phase < 7; phase++) begin
      if (phase == 0)
        configure(NUM_PAGES, NUM_PAGES, 1'b1);
      else
        configure(pick_register_value(), pick_register_value(), $urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 20;
        default: idle_pct = 45;
      endcase
      if (phase == 6) idle_pct = 0;
      repeat (150) random_request();
    end
  endtask

  // Check each result against the oldest prediction
  always @(posedge clk) begin : check_result
    request_rec_t want;
    outcome_t     seen;
    if (rst_n && out_valid) begin
      seen = {out_ok, out_count, out_freed, out_managed, out_overflow};
      if (pending_outcomes.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result: ok=%0b count=%0d freed=%0b managed=%0b overflow=%0b",
                   seen.ok, seen.count, seen.freed, seen.managed, seen.overflow);
      end else begin
        want = pending_outcomes.pop_front();
        if (seen.ok !== want.res.ok || seen.count !== want.res.count ||
            seen.freed !== want.res.freed || seen.managed !== want.res.managed ||
            seen.overflow !== want.res.overflow) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("mismatch func=%0d addr=%h", want.fn, want.addr);
            $display("  expected ok=%0b count=%0d freed=%0b managed=%0b overflow=%0b",
                     want.res.ok, want.res.count, want.res.freed, want.res.managed,
                     want.res.overflow);
            $display("  actual   ok=%0b count=%0d freed=%0b managed=%0b overflow=%0b",
                     seen.ok, seen.count, seen.freed, seen.managed, seen.overflow);
          end
        end
      end
    end
  end

  // Main sequence
  initial begin
    for (int i = 0; i < NUM_PAGES; i++) begin
      page_counts[i]  = '0;
      managed_bits[i] = 1'b0;
    end
    limit_pages = '0;
    map_len     = '0;
    tbl_ready   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_operations();
    test_register_extremes();
    test_deep_count();
    test_random_traffic();
    drain_results();
    if (fault_count == 0)
      $display("page_refcount_table_top_tb: clean");
    else
      $display("page_refcount_table_top_tb: errors");
    $finish;
  end

  // Hold a hard limit on the run
  initial begin
    #4000000;
    $display("page_refcount_table_top_tb: errors");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/prt_pkg.sv
src/prt_ram.sv
src/prt_ctrl.sv
src/prt_datapath.sv
src/page_refcount_table_top.sv
src/prt_checker.sv
tb/sv/page_refcount_table_top_tb.sv
